[rtl/u8t_pkg.sv]
// Shared types and constants for the UTF-8 / double-byte transcoder.
// No dependencies.

package u8t_pkg;

  localparam logic DirEncode = 1'b0;  // internal code to UTF-8
  localparam logic DirDecode = 1'b1;  // UTF-8 to internal code

  localparam int unsigned QDepth = 2;  // power of two
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned MaxBytes = 3;

  // one classified input byte: up to three result bytes, lowest index first
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] data;
    logic [1:0]               cnt;
    logic                     str_end;
  } job_t;

endpackage

[rtl/u8t_front.sv]
// Front end: takes input beats, tracks partial characters, builds result jobs.
// Depends on u8t_pkg.

module u8t_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          in_fire_i,
  input  logic [7:0]    in_byte_i,
  output logic          push_o,
  output u8t_pkg::job_t job_o
);

  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendOne  = 2'd1;
  localparam logic [1:0] PendTwo  = 2'd2;

  logic        dir_q;
  logic [1:0]  pend_q, pend_d;
  logic [15:0] part_q, part_d;
  logic [15:0] cp_enc, cp_dec;

  assign cp_enc = {part_q[15:8], in_byte_i};
  assign cp_dec = part_q | {10'd0, in_byte_i[5:0]};

  always_comb begin
    pend_d        = pend_q;
    part_d        = part_q;
    job_o.data    = '0;
    job_o.cnt     = 2'd0;
    job_o.str_end = 1'b0;
    if (in_byte_i == 8'h00) begin
      pend_d        = PendNone;
      part_d        = '0;
      job_o.cnt     = 2'd1;
      job_o.str_end = 1'b1;
    end else if (dir_q == u8t_pkg::DirEncode) begin
      if (pend_q == PendOne) begin
        pend_d = PendNone;
        part_d = '0;
        if (cp_enc <= 16'h007F) begin
          job_o.data[0] = cp_enc[7:0];
          job_o.cnt     = 2'd1;
        end else if (cp_enc <= 16'h07FF) begin
          job_o.data[0] = {3'b110, cp_enc[10:6]};
          job_o.data[1] = {2'b10, cp_enc[5:0]};
          job_o.cnt     = 2'd2;
        end else begin
          job_o.data[0] = {4'b1110, cp_enc[15:12]};
          job_o.data[1] = {2'b10, cp_enc[11:6]};
          job_o.data[2] = {2'b10, cp_enc[5:0]};
          job_o.cnt     = 2'd3;
        end
      end else if (!in_byte_i[7]) begin
        pend_d        = PendNone;
        job_o.data[0] = in_byte_i;
        job_o.cnt     = 2'd1;
      end else begin
        part_d = {1'b0, in_byte_i[6:0], 8'd0};
        pend_d = PendOne;
      end
    end else begin
      if (pend_q == PendTwo) begin
        part_d = part_q | {4'd0, in_byte_i[5:0], 6'd0};
        pend_d = PendOne;
      end else if (pend_q == PendOne) begin
        pend_d = PendNone;
        part_d = '0;
        if (cp_dec < 16'h0080) begin
          job_o.data[0] = cp_dec[7:0];
          job_o.cnt     = 2'd1;
        end else begin
          job_o.data[0] = {1'b1, cp_dec[14:8]};
          job_o.data[1] = cp_dec[7:0];
          job_o.cnt     = 2'd2;
        end
      end else if (!in_byte_i[7]) begin
        pend_d        = PendNone;
        job_o.data[0] = in_byte_i;
        job_o.cnt     = 2'd1;
      end else if (in_byte_i[7:5] == 3'b110) begin
        part_d = {5'd0, in_byte_i[4:0], 6'd0};
        pend_d = PendOne;
      end else begin
        part_d = {in_byte_i[3:0], 12'd0};
        pend_d = PendTwo;
      end
    end
  end

  assign push_o = in_fire_i && (job_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= u8t_pkg::DirEncode;
      pend_q <= PendNone;
      part_q <= '0;
    end else if (cfg_we_i) begin
      dir_q  <= cfg_wdata_i;
      pend_q <= PendNone;
      part_q <= '0;
    end else if (in_fire_i) begin
      pend_q <= pend_d;
      part_q <= part_d;
    end
  end

endmodule

[rtl/u8t_queue.sv]
// Short job queue between the front and back ends.
// Depends on u8t_pkg.

module u8t_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  u8t_pkg::job_t push_job_i,
  input  logic          pop_i,
  output u8t_pkg::job_t pop_job_o,
  output logic          full_o,
  output logic          avail_o
);

  u8t_pkg::job_t                  mem_q [u8t_pkg::QDepth];
  logic [u8t_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [u8t_pkg::QCntW-1:0]      cnt_q;

  assign full_o    = (cnt_q == u8t_pkg::QCntW'(u8t_pkg::QDepth));
  assign avail_o   = (cnt_q != '0);
  assign pop_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // pointers wrap naturally, depth is a power of two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/u8t_back.sv]
// Back end: plays each job out, one byte per cycle while ready_i is high.
// Depends on u8t_pkg.

module u8t_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          avail_i,
  input  u8t_pkg::job_t job_i,
  output logic          pop_o,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [7:0]    byte_o,
  output logic          last_o,
  output logic          end_o
);

  logic          busy_q;
  u8t_pkg::job_t job_q;
  logic [1:0]    idx_q;
  logic          fire;

  assign fire    = busy_q && ready_i;
  assign last_o  = (idx_q == job_q.cnt - 2'd1);
  assign valid_o = busy_q;
  assign byte_o  = job_q.data[idx_q];
  assign end_o   = job_q.str_end;
  assign pop_o   = avail_i && (!busy_q || (fire && last_o));

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (fire) begin
      if (last_o) begin
        busy_q <= 1'b0;
        idx_q  <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule

[rtl/utf8_double_byte_transcoder.sv]
// Top level of the UTF-8 / double-byte transcoder.
// Depends on u8t_pkg, u8t_front, u8t_queue, u8t_back.
//
//   group   dir  tdata            tuser        tlast
//   s_axis  in   in_byte[7:0]     -            -
//   m_axis  out  out_byte[7:0]    string_end   run_last
//   cfg     in   direction (wdata, write enable only)
//
// One input beat is taken per cycle while the job queue has room; each is
// classified in the same cycle. The back end sends one byte per cycle while
// m_axis_tready is high, so a character of n result bytes takes n beats:
// three output bytes per two input bytes on sustained 3-byte encoding. Jobs
// pass through the queue and the back end's job register. Reset clears state
// and empties the queue. Either side may stall; the queue decouples them.

module utf8_double_byte_transcoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // [0] string_end
);

  u8t_pkg::job_t push_job, pop_job;
  logic          push, pop, full, avail, in_fire;

  assign s_axis_tready = !full;
  assign in_fire       = s_axis_tvalid && !full;

  u8t_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .in_byte_i   (s_axis_tdata),
    .push_o      (push),
    .job_o       (push_job)
  );

  u8t_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .full_o     (full),
    .avail_o    (avail)
  );

  u8t_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .job_i   (pop_job),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .byte_o  (m_axis_tdata),
    .last_o  (m_axis_tlast),
    .end_o   (m_axis_tuser)
  );

endmodule

[rtl/u8t_checker.sv]
// Port-level checks for the transcoder, bound to the top level.
// No package dependencies.

module u8t_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  a_idle_in_reset: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  a_end_is_lone_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'h00))
    else $error("string end beat not a lone zero");

  // every non-final byte of a character is a lead or continuation byte
  a_inner_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[7])
    else $error("inner beat without top bit");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled beat changed");

endmodule

bind utf8_double_byte_transcoder u8t_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
